// ----- sv/tts_pkg.sv -----
// package for the transposition table store/probe block
// item, entry, config and result types plus kind and register codes
`default_nettype none

package tts_pkg;

    localparam logic [1:0] KIND_STORE = 2'd0;
    localparam logic [1:0] KIND_PROBE = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] CFG_MATE_SCORE    = 2'd0;
    localparam logic [1:0] CFG_UNKNOWN_SCORE = 2'd1;
    localparam logic [1:0] CFG_NULL_MIN      = 2'd2;

    localparam logic [1:0] BOUND_UPPER = 2'd2;

    localparam int MATE_WINDOW = 64;

    localparam logic [14:0] MATE_SCORE_RST   = 15'd10000;
    localparam logic [15:0] UNKNOWN_SCORE_RST = 16'h8000;
    localparam logic [6:0]  NULL_MIN_RST     = 7'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [63:0]        position_key;
        logic [1:0]         bound_kind;
        logic [6:0]         search_depth;
        logic signed [15:0] score_in;
        logic signed [15:0] beta_in;
        logic [31:0]        move_in;
        logic [6:0]         ply_in;
    } t_item;

    typedef struct packed {
        logic [63:0]        key;
        logic [1:0]         bound;
        logic [6:0]         depth;
        logic signed [15:0] score;
        logic [31:0]        move;
    } t_entry;

    typedef struct packed {
        logic [14:0]        mate_score;
        logic signed [15:0] unknown_score;
        logic [6:0]         null_min_depth;
    } t_cfg;

    typedef struct packed {
        logic               key_matched;
        logic signed [15:0] score_out;
        logic [1:0]         bound_out;
        logic [31:0]        move_out;
        logic               null_allowed;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/tts_mem.sv -----
// entry memory: one write port, one read port, registered read data
// uses t_entry from tts_pkg
`default_nettype none

module tts_mem
    import tts_pkg::*;
#(
    parameter int INDEX_BITS = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [INDEX_BITS-1:0] i_waddr,
    input  wire t_entry                i_wdata,
    input  wire logic                  i_re,
    input  wire logic [INDEX_BITS-1:0] i_raddr,
    output t_entry                     o_rdata
);

    localparam int DEPTH = 1 << INDEX_BITS;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/tts_calc.sv -----
// entry update and probe result logic, working on one read entry
// uses item, entry, config and result types from tts_pkg
`default_nettype none

module tts_calc
    import tts_pkg::*;
(
    input  wire t_item   i_item,
    input  wire t_entry  i_entry,
    input  wire t_cfg    i_cfg,
    output logic         o_we,
    output t_entry       o_wentry,
    output t_result      o_result
);

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] res;
        if (v > 18'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // magnitude above mate_score - window
    function automatic logic near_mate(input logic signed [15:0] s,
                                       input logic [14:0] mate);
        logic signed [17:0] s18;
        logic signed [17:0] mag;
        logic signed [17:0] thr;
        s18 = {{2{s[15]}}, s};
        mag = s18[17] ? -s18 : s18;
        thr = $signed({3'b000, mate}) - 18'(MATE_WINDOW);
        return mag > thr;
    endfunction

    logic signed [17:0] st_s18;
    logic signed [17:0] pr_s18;
    logic signed [17:0] ply18;
    logic signed [17:0] st_adj;
    logic signed [17:0] pr_adj;
    logic signed [15:0] st_score;
    logic signed [15:0] pr_score;
    logic               matched;
    logic               usable;

    always_comb begin
        ply18  = $signed({11'b0, i_item.ply_in});
        st_s18 = {{2{i_item.score_in[15]}}, i_item.score_in};
        pr_s18 = {{2{i_entry.score[15]}}, i_entry.score};
        // store pushes mate scores outward, probe pulls them back
        st_adj = (st_s18 > 18'sd0) ? st_s18 + ply18 : st_s18 - ply18;
        pr_adj = (pr_s18 > 18'sd0) ? pr_s18 - ply18 : pr_s18 + ply18;
        st_score = near_mate(i_item.score_in, i_cfg.mate_score) ? sat16(st_adj)
                                                                : i_item.score_in;
        pr_score = near_mate(i_entry.score, i_cfg.mate_score) ? sat16(pr_adj)
                                                              : i_entry.score;
    end

    assign o_we = (i_item.kind == KIND_STORE) && (i_entry.depth <= i_item.search_depth);

    always_comb begin
        o_wentry.key   = i_item.position_key;
        o_wentry.bound = i_item.bound_kind;
        o_wentry.depth = i_item.search_depth;
        o_wentry.score = st_score;
        o_wentry.move  = i_item.move_in;
    end

    assign matched = (i_entry.key == i_item.position_key);
    assign usable  = matched && (i_entry.depth >= i_item.search_depth);

    always_comb begin
        o_result = '0;
        if (i_item.kind == KIND_PROBE) begin
            o_result.key_matched  = matched;
            o_result.move_out     = matched ? i_entry.move : 32'd0;
            o_result.score_out    = usable ? pr_score : i_cfg.unknown_score;
            o_result.bound_out    = usable ? i_entry.bound : 2'd0;
            o_result.null_allowed = !(matched
                                      && (i_entry.depth >= i_cfg.null_min_depth)
                                      && (i_entry.score < i_item.beta_in)
                                      && (i_entry.bound == BOUND_UPPER));
        end
    end

endmodule

`default_nettype wire

// ----- sv/transposition_table_store_probe.sv -----
// direct-mapped transposition table, store / probe / clear per word
// result register loads when BUSY finishes, which waits while the output stalls;
// input stalls outside IDLE (entry read at accept, then update and write back)
// clear word: sweeps 2^INDEX_BITS entries, then gives its result through BUSY
// reset: config registers to defaults, then a clearing pass over 2^INDEX_BITS
// entries with input stalled; config writes are taken throughout
`default_nettype none

module transposition_table_store_probe
    import tts_pkg::*;
#(
    parameter int INDEX_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [63:0] i_position_key,
    input  wire logic [1:0]  i_bound_kind,
    input  wire logic [6:0]  i_search_depth,
    input  wire logic [15:0] i_score_in,
    input  wire logic [15:0] i_beta_in,
    input  wire logic [31:0] i_move_in,
    input  wire logic [6:0]  i_ply_in,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_key_matched,
    output logic [15:0]      o_score_out,
    output logic [1:0]       o_bound_out,
    output logic [31:0]      o_move_out,
    output logic             o_null_allowed,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [INDEX_BITS-1:0] r_clr_cnt, n_clr_cnt;
    logic                  r_clr_emit, n_clr_emit;
    logic                  r_out_valid, n_out_valid;
    t_item                 r_item;
    t_result               r_result;
    t_cfg                  r_cfg;

    t_item   in_item;
    t_entry  rd_entry;
    t_entry  calc_wentry;
    t_entry  mem_wdata;
    t_result calc_result;
    logic    calc_we;
    logic    in_acc;
    logic    finish;
    logic    mem_we;
    logic [INDEX_BITS-1:0] mem_waddr;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign finish      = (r_state == ST_BUSY) && (!r_out_valid || !i_out_stall);

    always_comb begin
        in_item.kind         = i_kind;
        in_item.position_key = i_position_key;
        in_item.bound_kind   = i_bound_kind;
        in_item.search_depth = i_search_depth;
        in_item.score_in     = i_score_in;
        in_item.beta_in      = i_beta_in;
        in_item.move_in      = i_move_in;
        in_item.ply_in       = i_ply_in;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mate_score     <= MATE_SCORE_RST;
            r_cfg.unknown_score  <= UNKNOWN_SCORE_RST;
            r_cfg.null_min_depth <= NULL_MIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MATE_SCORE:    r_cfg.mate_score     <= i_cfg_data[14:0];
                CFG_UNKNOWN_SCORE: r_cfg.unknown_score  <= i_cfg_data;
                CFG_NULL_MIN:      r_cfg.null_min_depth <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    tts_mem #(
        .INDEX_BITS(INDEX_BITS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (in_acc),
        .i_raddr(i_position_key[INDEX_BITS-1:0]),
        .o_rdata(rd_entry)
    );

    tts_calc u_calc (
        .i_item  (r_item),
        .i_entry (rd_entry),
        .i_cfg   (r_cfg),
        .o_we    (calc_we),
        .o_wentry(calc_wentry),
        .o_result(calc_result)
    );

    // clearing sweep owns the write port, otherwise the store write-back
    always_comb begin
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_cnt;
            mem_wdata = '0;
        end else begin
            mem_we    = finish && calc_we;
            mem_waddr = r_item.position_key[INDEX_BITS-1:0];
            mem_wdata = calc_wentry;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_clr_emit  = r_clr_emit;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_kind == KIND_CLEAR) begin
                        n_state    = ST_CLEAR;
                        n_clr_cnt  = '0;
                        n_clr_emit = 1'b1;
                    end else begin
                        n_state = ST_BUSY;
                    end
                end
            end
            ST_BUSY: begin
                if (finish) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + {{(INDEX_BITS-1){1'b0}}, 1'b1};
                if (&r_clr_cnt) begin
                    // a clear word still owes its result, the reset sweep does not
                    n_state = r_clr_emit ? ST_BUSY : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_clr_emit  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_clr_emit  <= n_clr_emit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= in_item;
        end
        if (finish) begin
            r_result <= calc_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_key_matched  = r_result.key_matched;
    assign o_score_out    = r_result.score_out;
    assign o_bound_out    = r_result.bound_out;
    assign o_move_out     = r_result.move_out;
    assign o_null_allowed = r_result.null_allowed;

endmodule

`default_nettype wire
